>>> rtl/aaws_pkg.sv
// Shared constants, register codes and the CORDIC angle table for the arctangent waveshaper.
`timescale 1ns / 1ps
package aaws_pkg;

   localparam int CORDIC_STEPS   = 28;
   localparam int ANGLE_BITS     = 32;
   localparam int STEEP_BITS     = 16;
   localparam int MIX_BITS       = 16;
   localparam int THR_BITS       = 23;
   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 32;
   localparam int MIX_FRAC_BITS  = 15;

   typedef logic signed [ANGLE_BITS-1:0] angle_type;

   localparam angle_type ANGLE_ONE = 32'sd1073741824;
   localparam logic [MIX_BITS-1:0] MIX_ONE = 16'h8000;
   localparam logic [STEEP_BITS-1:0] STEEP_RESET = 16'd256;
   localparam logic [MIX_BITS-1:0] MIX_RESET = 16'd0;
   localparam logic [THR_BITS-1:0] THR_RESET = 23'd8389;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_POS_STEEPNESS   = 3'd0,
      CSR_NEG_STEEPNESS   = 3'd1,
      CSR_POS_MIX         = 3'd2,
      CSR_NEG_MIX         = 3'd3,
      CSR_NOISE_THRESHOLD = 3'd4
   } csr_index_type;

   function automatic angle_type atan_angle(input int step);
      angle_type result;
      case (step)
         0:  result = 32'sd536870912;
         1:  result = 32'sd316933406;
         2:  result = 32'sd167458907;
         3:  result = 32'sd85004756;
         4:  result = 32'sd42667331;
         5:  result = 32'sd21354465;
         6:  result = 32'sd10679838;
         7:  result = 32'sd5340245;
         8:  result = 32'sd2670163;
         9:  result = 32'sd1335087;
         10: result = 32'sd667544;
         11: result = 32'sd333772;
         12: result = 32'sd166886;
         13: result = 32'sd83443;
         14: result = 32'sd41721;
         15: result = 32'sd20860;
         16: result = 32'sd10430;
         17: result = 32'sd5215;
         18: result = 32'sd2607;
         19: result = 32'sd1303;
         20: result = 32'sd651;
         21: result = 32'sd325;
         22: result = 32'sd162;
         23: result = 32'sd81;
         24: result = 32'sd40;
         25: result = 32'sd20;
         26: result = 32'sd10;
         27: result = 32'sd5;
         default: result = '0;
      endcase
      return result;
   endfunction

endpackage

>>> rtl/asymmetric_atan_waveshaper_top.sv
// Asymmetric arctangent soft clipper: one signed sample in, one shaped sample out.
// Each result is strobed on rsp_valid after the input, CORDIC, mix and output registers.
// Throughput: one request per cycle; busy stays low and the 28-stage CORDIC never stalls.
// Results cannot be held off by the receiver; each is shown for exactly one cycle.
// Reset clears the pipeline valid bits and loads the register defaults.
`timescale 1ns / 1ps
module asymmetric_atan_waveshaper_top #(
   parameter int SAMPLE_BITS = 24
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   output logic                                  busy,
   input  logic signed [SAMPLE_BITS-1:0]         req_sample_in,
   output logic                                  rsp_valid,
   output logic signed [SAMPLE_BITS-1:0]         rsp_sample_out,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [aaws_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [aaws_pkg::CSR_DATA_BITS-1:0]    csr_data
);
   import aaws_pkg::*;

   localparam int FRAC_BITS  = SAMPLE_BITS - 1;
   localparam int T_BITS     = SAMPLE_BITS + STEEP_BITS;
   localparam int CW         = SAMPLE_BITS + 18;
   localparam int TAG_STAGES = CORDIC_STEPS + 4;
   localparam int ZSH        = (FRAC_BITS <= 30) ? (30 - FRAC_BITS) : 0;
   localparam int ZSHL       = (FRAC_BITS > 30) ? (FRAC_BITS - 30) : 0;
   localparam int PROD_BITS  = SAMPLE_BITS + MIX_BITS;
   localparam int SUM_BITS   = PROD_BITS + 1;
   localparam int MAG_BITS   = SUM_BITS - MIX_FRAC_BITS;
   localparam logic [32:0] ZROUND = 33'((64'd1 << ZSH) >> 1);
   localparam logic [CW-1:0] X_INIT = CW'(64'd1 << (FRAC_BITS + 8));
   localparam logic [SUM_BITS-1:0] MIX_HALF = SUM_BITS'(64'd1 << (MIX_FRAC_BITS - 1));
   localparam logic [MAG_BITS-1:0] NEG_LIM = MAG_BITS'(64'd1 << FRAC_BITS);
   localparam logic [MAG_BITS-1:0] POS_LIM = MAG_BITS'((64'd1 << FRAC_BITS) - 64'd1);
   localparam logic [SAMPLE_BITS-1:0] ZF_MAX = SAMPLE_BITS'(64'd1 << FRAC_BITS);

   function automatic logic [SAMPLE_BITS-1:0] magnitude(input logic signed [SAMPLE_BITS-1:0] v);
      logic signed [SAMPLE_BITS-1:0] n;
      n = -v;
      return v[SAMPLE_BITS-1] ? SAMPLE_BITS'(n) : SAMPLE_BITS'(v);
   endfunction

   logic [STEEP_BITS-1:0] pos_steep_ff;
   logic [STEEP_BITS-1:0] neg_steep_ff;
   logic [MIX_BITS-1:0]   pos_mix_ff;
   logic [MIX_BITS-1:0]   neg_mix_ff;
   logic [THR_BITS-1:0]   noise_threshold_ff;

   logic                          vld_ff  [0:TAG_STAGES-1];
   logic signed [SAMPLE_BITS-1:0] x_ff    [0:TAG_STAGES-1];
   logic                          neg_ff  [0:TAG_STAGES-1];
   logic                          pass_ff [1:TAG_STAGES-1];
   logic [SAMPLE_BITS-1:0]        a_ff;

   logic [STEEP_BITS-1:0]   steep_sel;
   logic [T_BITS-1:0]       t_ff;
   logic                    pass_in;

   logic signed [CW-1:0]    cx [0:CORDIC_STEPS];
   logic signed [CW-1:0]    cy [0:CORDIC_STEPS];
   angle_type               cz [0:CORDIC_STEPS];

   logic [30:0]             z_clamp;
   logic [32:0]             z_round;
   logic [SAMPLE_BITS-1:0]  zf_in;
   logic [SAMPLE_BITS-1:0]  zf_ff;
   logic [SAMPLE_BITS-1:0]  a2_ff;
   logic [MIX_BITS-1:0]     mix_raw;
   logic [MIX_BITS-1:0]     mix_in;
   logic [MIX_BITS-1:0]     mix_ff;

   logic [PROD_BITS-1:0]    wet_ff;
   logic [PROD_BITS-1:0]    dry_ff;
   logic [SUM_BITS-1:0]     sum;
   logic [MAG_BITS-1:0]     mag;
   logic [MAG_BITS-1:0]     mag_sat;
   logic [MAG_BITS-1:0]     mag_neg;
   logic signed [SAMPLE_BITS-1:0] result_in;

   logic                          rsp_valid_ff;
   logic signed [SAMPLE_BITS-1:0] rsp_sample_ff;

   assign busy      = 1'b0;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_steep_ff       <= STEEP_RESET;
         neg_steep_ff       <= STEEP_RESET;
         pos_mix_ff         <= MIX_RESET;
         neg_mix_ff         <= MIX_RESET;
         noise_threshold_ff <= THR_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index_type'(csr_index))
            CSR_POS_STEEPNESS:   pos_steep_ff       <= csr_data[STEEP_BITS-1:0];
            CSR_NEG_STEEPNESS:   neg_steep_ff       <= csr_data[STEEP_BITS-1:0];
            CSR_POS_MIX:         pos_mix_ff         <= csr_data[MIX_BITS-1:0];
            CSR_NEG_MIX:         neg_mix_ff         <= csr_data[MIX_BITS-1:0];
            CSR_NOISE_THRESHOLD: noise_threshold_ff <= csr_data[THR_BITS-1:0];
            default: ;
         endcase
      end
   end

   // advance valid bits every cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < TAG_STAGES; k++) begin
            vld_ff[k] <= 1'b0;
         end
         rsp_valid_ff <= 1'b0;
      end else begin
         vld_ff[0] <= start && !busy;
         for (int k = 1; k < TAG_STAGES; k++) begin
            vld_ff[k] <= vld_ff[k-1];
         end
         rsp_valid_ff <= vld_ff[TAG_STAGES-1];
      end
   end

   assign steep_sel = neg_ff[0] ? neg_steep_ff : pos_steep_ff;
   assign pass_in   = 33'(a_ff) <= 33'(noise_threshold_ff);

   always_ff @(posedge clock) begin
      x_ff[0]   <= req_sample_in;
      neg_ff[0] <= req_sample_in[SAMPLE_BITS-1];
      a_ff      <= magnitude(req_sample_in);
      t_ff      <= T_BITS'(steep_sel) * T_BITS'(a_ff);
      pass_ff[1] <= pass_in;
      for (int k = 1; k < TAG_STAGES; k++) begin
         x_ff[k]   <= x_ff[k-1];
         neg_ff[k] <= neg_ff[k-1];
      end
      for (int k = 2; k < TAG_STAGES; k++) begin
         pass_ff[k] <= pass_ff[k-1];
      end
   end

   assign cx[0] = signed'(X_INIT);
   assign cy[0] = signed'(CW'(t_ff));
   assign cz[0] = '0;

   for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_cordic
      aaws_cordic_stage #(
         .WIDTH (CW),
         .STEP  (k)
      ) u_stage (
         .clock (clock),
         .in_x  (cx[k]),
         .in_y  (cy[k]),
         .in_z  (cz[k]),
         .out_x (cx[k+1]),
         .out_y (cy[k+1]),
         .out_z (cz[k+1])
      );
   end

   always_comb begin
      if (cz[CORDIC_STEPS][ANGLE_BITS-1]) begin
         z_clamp = '0;
      end else if (cz[CORDIC_STEPS] > ANGLE_ONE) begin
         z_clamp = 31'(ANGLE_ONE);
      end else begin
         z_clamp = 31'(cz[CORDIC_STEPS]);
      end
      z_round = 33'(z_clamp) + ZROUND;
      zf_in   = SAMPLE_BITS'((z_round >> ZSH) << ZSHL);
      mix_raw = neg_ff[TAG_STAGES-3] ? neg_mix_ff : pos_mix_ff;
      mix_in  = (mix_raw > MIX_ONE) ? MIX_ONE : mix_raw;
   end

   always_ff @(posedge clock) begin
      zf_ff  <= zf_in;
      a2_ff  <= magnitude(x_ff[TAG_STAGES-3]);
      mix_ff <= mix_in;
      wet_ff <= PROD_BITS'(mix_ff) * PROD_BITS'(zf_ff);
      dry_ff <= PROD_BITS'(MIX_ONE - mix_ff) * PROD_BITS'(a2_ff);
   end

   always_comb begin
      sum = SUM_BITS'(wet_ff) + SUM_BITS'(dry_ff) + MIX_HALF;
      mag = MAG_BITS'(sum >> MIX_FRAC_BITS);
      if (neg_ff[TAG_STAGES-1]) begin
         mag_sat = (mag > NEG_LIM) ? NEG_LIM : mag;
      end else begin
         mag_sat = (mag > POS_LIM) ? POS_LIM : mag;
      end
      mag_neg = -mag_sat;
      if (pass_ff[TAG_STAGES-1]) begin
         result_in = x_ff[TAG_STAGES-1];
      end else if (neg_ff[TAG_STAGES-1]) begin
         result_in = signed'(mag_neg[SAMPLE_BITS-1:0]);
      end else begin
         result_in = signed'(mag_sat[SAMPLE_BITS-1:0]);
      end
   end

   always_ff @(posedge clock) begin
      rsp_sample_ff <= result_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_sample_out = rsp_sample_ff;

`ifndef NO_ASSERTIONS
   a_rsp_from_request: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> $past(start && !busy, TAG_STAGES + 1))
      else $error("result strobed without a matching request");

   a_pos_sign: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !$past(neg_ff[TAG_STAGES-1]) |-> !rsp_sample_ff[SAMPLE_BITS-1])
      else $error("positive sample produced a negative result");

   a_neg_sign: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && $past(neg_ff[TAG_STAGES-1])
         |-> rsp_sample_ff[SAMPLE_BITS-1] || rsp_sample_ff == '0)
      else $error("negative sample produced a positive result");

   a_zf_range: assert property (@(posedge clock) disable iff (reset)
      vld_ff[TAG_STAGES-2] |-> zf_ff <= ZF_MAX)
      else $error("scaled arctangent exceeds full scale");
`endif

endmodule

>>> rtl/aaws_cordic_stage.sv
// One registered CORDIC vectoring iteration of the arctangent pipeline.
`timescale 1ns / 1ps
module aaws_cordic_stage #(
   parameter int WIDTH = 42,
   parameter int STEP  = 0
) (
   input  logic                     clock,
   input  logic signed [WIDTH-1:0]  in_x,
   input  logic signed [WIDTH-1:0]  in_y,
   input  aaws_pkg::angle_type      in_z,
   output logic signed [WIDTH-1:0]  out_x,
   output logic signed [WIDTH-1:0]  out_y,
   output aaws_pkg::angle_type      out_z
);
   import aaws_pkg::*;

   logic signed [WIDTH-1:0] dx;
   logic signed [WIDTH-1:0] dy;
   logic signed [WIDTH-1:0] x_in;
   logic signed [WIDTH-1:0] y_in;
   angle_type               z_in;
   logic signed [WIDTH-1:0] x_ff;
   logic signed [WIDTH-1:0] y_ff;
   angle_type               z_ff;

   assign dx = in_y >>> STEP;
   assign dy = in_x >>> STEP;

   always_comb begin
      if (!in_y[WIDTH-1]) begin
         x_in = in_x + dx;
         y_in = in_y - dy;
         z_in = in_z + atan_angle(STEP);
      end else begin
         x_in = in_x - dx;
         y_in = in_y + dy;
         z_in = in_z - atan_angle(STEP);
      end
   end

   always_ff @(posedge clock) begin
      x_ff <= x_in;
      y_ff <= y_in;
      z_ff <= z_in;
   end

   assign out_x = x_ff;
   assign out_y = y_ff;
   assign out_z = z_ff;

endmodule

>>> dv/asymmetric_atan_waveshaper_top_tb.sv
// Self-checking testbench for the asymmetric arctangent waveshaper: predicts every shaped sample.
`timescale 1ns / 1ps
module asymmetric_atan_waveshaper_top_tb;
   import aaws_pkg::*;

   localparam int SAMPLE_BITS    = 24;
   localparam int FRAC_BITS      = SAMPLE_BITS - 1;
   localparam int CLOCK_PERIOD   = 10;
   localparam int PIPE_LATENCY   = 32;
   localparam int CYCLE_LIMIT    = 200000;
   localparam int RANDOM_PHASES  = 14;
   localparam int PHASE_REQUESTS = 100;
   localparam int QUIET_PHASES   = 2;
   localparam int ROTATIONS      = 28;
   localparam int MIX_SHIFT      = 15;

   typedef logic signed [SAMPLE_BITS-1:0] sample_type;
   typedef struct packed {
      sample_type sample_in;
      sample_type shaped;
   } shaped_entry_type;

   localparam longint SAMPLE_MAX = (64'sd1 <<< FRAC_BITS) - 1;
   localparam longint SAMPLE_MIN = -(64'sd1 <<< FRAC_BITS);
   localparam longint ANGLE_FULL = 64'sd1 <<< 30;
   localparam logic [STEEP_BITS-1:0] STEEP_DEFAULT = 16'd256;
   localparam logic [MIX_BITS-1:0] MIX_NONE = 16'd0;
   localparam logic [MIX_BITS-1:0] MIX_FULL = 16'd32768;
   localparam logic [THR_BITS-1:0] THR_DEFAULT = 23'd8389;
   localparam logic [THR_BITS-1:0] THR_MAX = '1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_UNMAPPED_LO = 3'd5;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_UNMAPPED_HI = 3'd7;
   localparam longint ATAN_STEP [ROTATIONS] = '{
      536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
      10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
      41721, 20860, 10430, 5215, 2607, 1303, 651, 325, 162, 81, 40, 20, 10, 5
   };

   class waveshaper_checker;
      logic [STEEP_BITS-1:0] pos_steep;
      logic [STEEP_BITS-1:0] neg_steep;
      logic [MIX_BITS-1:0]   pos_mix;
      logic [MIX_BITS-1:0]   neg_mix;
      logic [THR_BITS-1:0]   threshold;
      shaped_entry_type      expected_samples[$];
      int unsigned           errors;

      function new();
         pos_steep = STEEP_DEFAULT;
         neg_steep = STEEP_DEFAULT;
         pos_mix = MIX_NONE;
         neg_mix = MIX_NONE;
         threshold = THR_DEFAULT;
         errors = 0;
      endfunction

      function void write_register(input logic [CSR_INDEX_BITS-1:0] index,
                                   input logic [CSR_DATA_BITS-1:0] data);
         case (index)
            CSR_POS_STEEPNESS: pos_steep = data[STEEP_BITS-1:0];
            CSR_NEG_STEEPNESS: neg_steep = data[STEEP_BITS-1:0];
            CSR_POS_MIX: pos_mix = data[MIX_BITS-1:0];
            CSR_NEG_MIX: neg_mix = data[MIX_BITS-1:0];
            CSR_NOISE_THRESHOLD: threshold = data[THR_BITS-1:0];
            default: ;
         endcase
      endfunction

      function sample_type shape_sample(input sample_type s);
         longint x, mag_in, steep, mix, cx, cy, cz, dx, dy, zf, mag, lim;
         logic neg;
         int i;
         x = longint'(s);
         if (x >= -longint'(threshold) && x <= longint'(threshold)) return s;
         neg = x < 0;
         mag_in = neg ? -x : x;
         steep = longint'(neg ? neg_steep : pos_steep);
         mix = longint'(neg ? neg_mix : pos_mix);
         if (mix > longint'(MIX_FULL)) mix = longint'(MIX_FULL);
         cx = 64'sd1 <<< (FRAC_BITS + 8);
         cy = steep * mag_in;
         cz = 0;
         for (i = 0; i < ROTATIONS; i++) begin
            dx = cy >>> i;
            dy = cx >>> i;
            if (cy >= 0) begin
               cx += dx;
               cy -= dy;
               cz += ATAN_STEP[i];
            end else begin
               cx -= dx;
               cy += dy;
               cz -= ATAN_STEP[i];
            end
         end
         if (cz < 0) cz = 0;
         if (cz > ANGLE_FULL) cz = ANGLE_FULL;
         if (FRAC_BITS < 30) zf = (cz + (64'sd1 <<< (29 - FRAC_BITS))) >>> (30 - FRAC_BITS);
         else zf = cz <<< (FRAC_BITS - 30);
         mag = (mix * zf + (longint'(MIX_FULL) - mix) * mag_in
                + (64'sd1 <<< (MIX_SHIFT - 1))) >>> MIX_SHIFT;
         if (neg) begin
            lim = 64'sd1 <<< FRAC_BITS;
            if (mag > lim) mag = lim;
            mag = -mag;
         end else begin
            lim = (64'sd1 <<< FRAC_BITS) - 1;
            if (mag > lim) mag = lim;
         end
         return mag[SAMPLE_BITS-1:0];
      endfunction

      function void accept_sample(input sample_type s);
         shaped_entry_type e;
         e.sample_in = s;
         e.shaped = shape_sample(s);
         expected_samples.push_back(e);
      endfunction

      function void compare_output(input sample_type actual);
         shaped_entry_type e;
         if (expected_samples.size() == 0) begin
            $display("%0t: unexpected sample_out: expected none, actual %0d", $time, actual);
            errors++;
         end else begin
            e = expected_samples.pop_front();
            if (actual !== e.shaped) begin
               $display("%0t: sample_out mismatch for sample_in %0d: expected %0d, actual %0d",
                        $time, e.sample_in, e.shaped, actual);
               errors++;
            end
         end
      endfunction

      function int pending();
         return expected_samples.size();
      endfunction
   endclass

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          start = 1'b0;
   logic                          busy;
   sample_type                    req_sample_in = '0;
   logic                          rsp_valid;
   sample_type                    rsp_sample_out;
   logic                          csr_valid = 1'b0;
   logic                          csr_ready;
   logic [CSR_INDEX_BITS-1:0]     csr_index = '0;
   logic [CSR_DATA_BITS-1:0]      csr_data = '0;
   int unsigned                   cycle_count = 0;
   waveshaper_checker             sb = new();

   asymmetric_atan_waveshaper_top #(
      .SAMPLE_BITS(SAMPLE_BITS)
   ) i_dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_sample_in(req_sample_in),
      .rsp_valid(rsp_valid),
      .rsp_sample_out(rsp_sample_out),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (start && !busy) sb.accept_sample(req_sample_in);
         if (rsp_valid) sb.compare_output(rsp_sample_out);
         if (csr_valid && csr_ready) sb.write_register(csr_index, csr_data);
      end
   end

   task automatic send_sample(input sample_type s);
      start <= 1'b1;
      req_sample_in <= s;
      do @(posedge clock); while (busy);
   endtask

   task automatic pause_requests(input int idle_pct);
      if ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         repeat ($urandom_range(19, 1)) @(posedge clock);
      end
   endtask

   task automatic drain_samples();
      start <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_INDEX_BITS-1:0] index,
                            input logic [CSR_DATA_BITS-1:0] value, input int width);
      logic [CSR_DATA_BITS-1:0] junk;
      junk = $urandom;
      if ($urandom_range(3) == 0) begin
         csr_valid <= 1'b0;
         repeat ($urandom_range(19, 1)) @(posedge clock);
      end
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data <= (junk << width) | value;
      do @(posedge clock); while (!csr_ready);
   endtask

   task automatic apply_setting(input logic [STEEP_BITS-1:0] ps, input logic [STEEP_BITS-1:0] ns,
                                input logic [MIX_BITS-1:0] pm, input logic [MIX_BITS-1:0] nm,
                                input logic [THR_BITS-1:0] thr);
      write_csr(CSR_POS_STEEPNESS, 32'(ps), STEEP_BITS);
      write_csr(CSR_NEG_STEEPNESS, 32'(ns), STEEP_BITS);
      write_csr(CSR_POS_MIX, 32'(pm), MIX_BITS);
      write_csr(CSR_NEG_MIX, 32'(nm), MIX_BITS);
      write_csr(CSR_NOISE_THRESHOLD, 32'(thr), THR_BITS);
      if ($urandom_range(1) == 1)
         write_csr(CSR_INDEX_BITS'($urandom_range(CSR_UNMAPPED_HI, CSR_UNMAPPED_LO)), '0, 0);
      csr_valid <= 1'b0;
   endtask

   function automatic logic [STEEP_BITS-1:0] pick_steep();
      case ($urandom_range(4))
         0: return '0;
         1: return '1;
         2: return STEEP_DEFAULT;
         3: return STEEP_BITS'($urandom_range(1023, 1));
         default: return STEEP_BITS'($urandom);
      endcase
   endfunction

   function automatic logic [MIX_BITS-1:0] pick_mix();
      case ($urandom_range(4))
         0: return MIX_NONE;
         1: return MIX_FULL;
         2: return MIX_BITS'($urandom_range(65535, 32769));
         default: return MIX_BITS'($urandom_range(32768));
      endcase
   endfunction

   function automatic logic [THR_BITS-1:0] pick_thr();
      case ($urandom_range(5))
         0: return '0;
         1: return THR_MAX;
         2: return THR_DEFAULT;
         3: return THR_BITS'($urandom_range(65535));
         default: return THR_BITS'($urandom);
      endcase
   endfunction

   function automatic sample_type pick_sample(input logic [THR_BITS-1:0] thr);
      sample_type s;
      longint v;
      s = sample_type'($urandom);
      case ($urandom_range(9))
         0, 1, 2, 3: v = longint'(s);
         4, 5, 6: begin
            v = longint'(thr) + longint'($urandom_range(8)) - 4;
            if ($urandom_range(1) == 1) v = -v;
         end
         7: v = longint'(s) >>> $urandom_range(22, 6);
         8: v = longint'(s) >>> 11;
         default: begin
            case ($urandom_range(5))
               0: v = SAMPLE_MAX;
               1: v = SAMPLE_MIN;
               2: v = -SAMPLE_MAX;
               3: v = 1;
               4: v = -1;
               default: v = 0;
            endcase
         end
      endcase
      if (v > SAMPLE_MAX) v = SAMPLE_MAX;
      if (v < SAMPLE_MIN) v = SAMPLE_MIN;
      return v[SAMPLE_BITS-1:0];
   endfunction

   task automatic run_phase(input int count, input int idle_pct, input logic [THR_BITS-1:0] thr);
      repeat (count) begin
         pause_requests(idle_pct);
         send_sample(pick_sample(thr));
      end
      drain_samples();
   endtask

   initial begin
      logic [THR_BITS-1:0] thr;
      int idle_pct;
      int p;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      send_sample('0);
      send_sample(sample_type'(1));
      send_sample(sample_type'(-1));
      send_sample(sample_type'(THR_DEFAULT));
      send_sample(sample_type'(longint'(THR_DEFAULT) + 1));
      send_sample(sample_type'(-longint'(THR_DEFAULT)));
      send_sample(sample_type'(-longint'(THR_DEFAULT) - 1));
      send_sample(sample_type'(SAMPLE_MAX));
      send_sample(sample_type'(SAMPLE_MIN));
      drain_samples();

      apply_setting('1, '0, MIX_FULL, '1, '0);
      send_sample(sample_type'(SAMPLE_MAX));
      send_sample(sample_type'(SAMPLE_MIN));
      send_sample(sample_type'(1));
      send_sample(sample_type'(-1));
      send_sample('0);
      send_sample(24'sh555555);
      send_sample(24'shAAAAAA);
      drain_samples();

      apply_setting(16'd1, '1, 16'd16384, MIX_FULL, THR_MAX);
      send_sample(sample_type'(SAMPLE_MAX));
      send_sample(sample_type'(SAMPLE_MIN));
      send_sample(sample_type'(-SAMPLE_MAX));
      send_sample('0);
      drain_samples();

      for (p = 0; p < RANDOM_PHASES; p++) begin
         thr = pick_thr();
         apply_setting(pick_steep(), pick_steep(), pick_mix(), pick_mix(), thr);
         case ($urandom_range(2))
            0: idle_pct = 0;
            1: idle_pct = 15;
            default: idle_pct = 50;
         endcase
         if (p >= RANDOM_PHASES - QUIET_PHASES) idle_pct = 0;
         run_phase(PHASE_REQUESTS, idle_pct, thr);
      end

      repeat (PIPE_LATENCY + 8) @(posedge clock);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
